@@ design/rls_pkg.sv @@
// Shared types, constants and the CRC-32 step function for the record log scanner.
// No dependencies; imported by rls_scan, record_log_scanner_core and the testbench files.
`timescale 1ns / 1ps

package rls_pkg;

   localparam logic [31:0] LOG_MAGIC    = 32'h4B42_4653;
   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
   localparam int unsigned PAD_MASK     = 3;
   localparam int unsigned HEADER_BYTES = 16;
   localparam int unsigned FIELD_W      = 15;   // width of offsets/lengths on the result

   typedef enum logic [2:0] {
      PH_MAGIC   = 3'd0,
      PH_LENGTH  = 3'd1,
      PH_SEQ     = 3'd2,
      PH_CRC     = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_STOPPED = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      STOP_EMPTY      = 3'd0,
      STOP_BAD_MAGIC  = 3'd1,
      STOP_BAD_LENGTH = 3'd2,
      STOP_OVERRUN    = 3'd3,
      STOP_CRC        = 3'd4,
      STOP_REGION_END = 3'd5
   } stop_type;

   // first member lands in the top bits, so found ends up in bit 0
   typedef struct packed {
      stop_type               stop_reason;
      logic [FIELD_W-1:0]     append_at;
      logic [31:0]            next_seq;
      logic [FIELD_W-1:0]     latest_length;
      logic [FIELD_W-1:0]     latest_offset;
      logic                   found;
   } result_type;

   localparam int unsigned RESULT_W   = $bits(result_type);
   localparam int unsigned RSP_DATA_W = ((RESULT_W + 7) / 8) * 8;

   // reflected CRC-32 over the low nbytes of data, lowest byte first
   function automatic logic [31:0] crc_update(input logic [31:0] crc_in,
                                              input logic [31:0] data,
                                              input logic [2:0]  nbytes);
      logic [31:0] c;
      c = crc_in;
      for (int k = 0; k < 4; k++) begin
         if (3'(k) < nbytes) begin
            c = c ^ {24'h0, data[8*k +: 8]};
            for (int b = 0; b < 8; b++) begin
               c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
            end
         end
      end
      return c;
   endfunction

endpackage

@@ design/rls_scan.sv @@
// Record parser: phase state, header checks, CRC over the payload, best-record tracking.
// Uses rls_pkg. Updates once per word handed over by the core's input register.
`timescale 1ns / 1ps

module rls_scan #(
   parameter int unsigned REGION_BYTES = 16384
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [31:0]         word,
   input  logic                start_req,
   output logic                res_valid,
   output rls_pkg::result_type res
);
   import rls_pkg::*;

   localparam int unsigned OFS_W = $clog2(REGION_BYTES) + 2;
   localparam logic [OFS_W-1:0] REGION_OFS = OFS_W'(REGION_BYTES);
   localparam logic [OFS_W-1:0] HDR_OFS    = OFS_W'(HEADER_BYTES);
   localparam logic [OFS_W-1:0] PAD_OFS    = OFS_W'(PAD_MASK);
   localparam logic [OFS_W-1:0] WORD_OFS   = OFS_W'(4);
   localparam logic [31:0]      REGION_32  = 32'(REGION_BYTES);

   phase_type        phase_ff, phase_in, cur_phase;
   logic [OFS_W-1:0] offset_ff, offset_in, cur_offset;
   logic [OFS_W-1:0] start_ff, start_in, cur_start;
   logic [OFS_W-1:0] len_ff, len_in, cur_len;
   logic [31:0]      seq_ff, seq_in, cur_seq;
   logic [31:0]      check_ff, check_in, cur_check;
   logic [31:0]      crc_ff, crc_in, cur_crc;
   logic [OFS_W-1:0] left_ff, left_in, cur_left;
   logic [OFS_W-1:0] best_ofs_ff, best_ofs_in, cur_best_ofs;
   logic [OFS_W-1:0] best_len_ff, best_len_in, cur_best_len;
   logic [31:0]      follow_ff, follow_in, cur_follow;
   logic [OFS_W-1:0] append_ff, append_in, cur_append;

   logic             w_empty, w_magic, len_bad, overrun, crc_bad, region_end, left_done;
   logic [OFS_W-1:0] len_word, pad_word, pad_rec, app_next, left_next;
   logic [2:0]       nbytes;
   logic [31:0]      crc_next;

   // a start request puts every piece of state back to reset before the word is parsed
   always_comb begin
      if (start_req) begin
         cur_phase    = PH_MAGIC;
         cur_offset   = '0;
         cur_start    = '0;
         cur_len      = '0;
         cur_seq      = '0;
         cur_check    = '0;
         cur_crc      = ALL_ONES;
         cur_left     = '0;
         cur_best_ofs = REGION_OFS;
         cur_best_len = '0;
         cur_follow   = 32'd1;
         cur_append   = '0;
      end else begin
         cur_phase    = phase_ff;
         cur_offset   = offset_ff;
         cur_start    = start_ff;
         cur_len      = len_ff;
         cur_seq      = seq_ff;
         cur_check    = check_ff;
         cur_crc      = crc_ff;
         cur_left     = left_ff;
         cur_best_ofs = best_ofs_ff;
         cur_best_len = best_len_ff;
         cur_follow   = follow_ff;
         cur_append   = append_ff;
      end
   end

   // word decode and checks
   always_comb begin
      w_empty    = (word == ALL_ONES);
      w_magic    = (word == LOG_MAGIC);
      len_bad    = (word == 32'd0) || (word > REGION_32);
      len_word   = OFS_W'(word);
      pad_word   = (len_word + PAD_OFS) & ~PAD_OFS;
      overrun    = (cur_start + HDR_OFS + pad_word) > REGION_OFS;
      nbytes     = (cur_left < WORD_OFS) ? 3'(cur_left) : 3'd4;
      crc_next   = crc_update(cur_crc, word, nbytes);
      left_next  = cur_left - OFS_W'(nbytes);
      left_done  = (left_next == '0);
      crc_bad    = ((~crc_next) != cur_check);
      pad_rec    = (cur_len + PAD_OFS) & ~PAD_OFS;
      app_next   = cur_start + HDR_OFS + pad_rec;
      region_end = (app_next + HDR_OFS) > REGION_OFS;
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         case (cur_phase)
            PH_MAGIC:   phase_in = (w_empty || !w_magic) ? PH_STOPPED : PH_LENGTH;
            PH_LENGTH:  phase_in = (len_bad || overrun) ? PH_STOPPED : PH_SEQ;
            PH_SEQ:     phase_in = PH_CRC;
            PH_CRC:     phase_in = PH_PAYLOAD;
            PH_PAYLOAD: begin
               if (!left_done) begin
                  phase_in = PH_PAYLOAD;
               end else if (crc_bad || region_end) begin
                  phase_in = PH_STOPPED;
               end else begin
                  phase_in = PH_MAGIC;
               end
            end
            default:    phase_in = PH_STOPPED;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      offset_in   = offset_ff;
      start_in    = start_ff;
      len_in      = len_ff;
      seq_in      = seq_ff;
      check_in    = check_ff;
      crc_in      = crc_ff;
      left_in     = left_ff;
      best_ofs_in = best_ofs_ff;
      best_len_in = best_len_ff;
      follow_in   = follow_ff;
      append_in   = append_ff;
      res_valid   = 1'b0;
      res.stop_reason = STOP_EMPTY;
      if (fire) begin
         offset_in   = cur_offset;
         start_in    = cur_start;
         len_in      = cur_len;
         seq_in      = cur_seq;
         check_in    = cur_check;
         crc_in      = cur_crc;
         left_in     = cur_left;
         best_ofs_in = cur_best_ofs;
         best_len_in = cur_best_len;
         follow_in   = cur_follow;
         append_in   = cur_append;
         if (cur_phase != PH_STOPPED) begin
            offset_in = cur_offset + WORD_OFS;
         end
         case (cur_phase)
            PH_MAGIC: begin
               if (w_empty) begin
                  res_valid       = 1'b1;
                  res.stop_reason = STOP_EMPTY;
               end else if (!w_magic) begin
                  res_valid       = 1'b1;
                  res.stop_reason = STOP_BAD_MAGIC;
               end else begin
                  start_in = cur_offset;
               end
            end
            PH_LENGTH: begin
               if (len_bad) begin
                  res_valid       = 1'b1;
                  res.stop_reason = STOP_BAD_LENGTH;
               end else if (overrun) begin
                  res_valid       = 1'b1;
                  res.stop_reason = STOP_OVERRUN;
               end else begin
                  len_in = len_word;
               end
            end
            PH_SEQ: begin
               seq_in = word;
            end
            PH_CRC: begin
               check_in = word;
               crc_in   = ALL_ONES;
               left_in  = cur_len;
            end
            PH_PAYLOAD: begin
               crc_in  = crc_next;
               left_in = left_next;
               if (left_done) begin
                  if (crc_bad) begin
                     res_valid       = 1'b1;
                     res.stop_reason = STOP_CRC;
                  end else begin
                     best_ofs_in = cur_start;
                     best_len_in = cur_len;
                     follow_in   = cur_seq + 32'd1;
                     append_in   = app_next;
                     offset_in   = app_next;
                     if (region_end) begin
                        res_valid       = 1'b1;
                        res.stop_reason = STOP_REGION_END;
                     end
                  end
               end
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
      res.found         = (best_ofs_in < REGION_OFS);
      res.latest_offset = FIELD_W'(best_ofs_in);
      res.latest_length = FIELD_W'(best_len_in);
      res.next_seq      = follow_in;
      res.append_at     = FIELD_W'(append_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_MAGIC;
         offset_ff   <= '0;
         start_ff    <= '0;
         len_ff      <= '0;
         seq_ff      <= '0;
         check_ff    <= '0;
         crc_ff      <= ALL_ONES;
         left_ff     <= '0;
         best_ofs_ff <= REGION_OFS;
         best_len_ff <= '0;
         follow_ff   <= 32'd1;
         append_ff   <= '0;
      end else begin
         phase_ff    <= phase_in;
         offset_ff   <= offset_in;
         start_ff    <= start_in;
         len_ff      <= len_in;
         seq_ff      <= seq_in;
         check_ff    <= check_in;
         crc_ff      <= crc_in;
         left_ff     <= left_in;
         best_ofs_ff <= best_ofs_in;
         best_len_ff <= best_len_in;
         follow_ff   <= follow_in;
         append_ff   <= append_in;
      end
   end

endmodule

@@ design/record_log_scanner_core.sv @@
// Record log scanner top level: input register, parser, result register.
// Uses rls_pkg and rls_scan.
`timescale 1ns / 1ps
//
//  channel | dir | tdata                         | tuser
//  req_    | in  | word[31:0]                    | start_req
//  rsp_    | out | found, latest_offset, ...     | -
//
//  One region word per cycle sustained while results are taken; the word
//  that causes a result passes through the input register, then the result
//  register, before the result is valid. The parser is a single CRC-32 over
//  four bytes plus header compares between the two.
//  Synchronous reset returns the parser to offset 0 awaiting a magic word.
//  While a result waits for rsp_tready no word is parsed; the input register
//  holds at most one more word, then req_tready is low until the result is taken.

module record_log_scanner_core #(
   parameter int unsigned REGION_BYTES = 16384
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,  // word[31:0]
   input  logic                               req_tuser,  // start_req
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // found[0], latest_offset[15:1], latest_length[30:16], next_seq[62:31],
   // append_at[77:63], stop_reason[80:78], zero fill above
   output logic [rls_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import rls_pkg::*;

   localparam int unsigned PAD_W = RSP_DATA_W - RESULT_W;

   logic        in_valid_ff, in_valid_in;
   logic [31:0] in_word_ff;
   logic        in_start_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_res_ff;
   logic        proc_fire;
   logic        res_valid;
   result_type  res;

   assign proc_fire  = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc_fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (proc_fire) begin
         out_valid_in = res_valid;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   rls_scan #(
      .REGION_BYTES (REGION_BYTES)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .fire      (proc_fire),
      .word      (in_word_ff),
      .start_req (in_start_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_word_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
      if (proc_fire && res_valid) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_res_ff};

endmodule

@@ tb/record_log_scanner_checker.sv @@
// Checker for record_log_scanner_core: watches both stream channels, predicts each scan
// summary from the accepted region words and compares it with what the core returns.
// Depends on rls_pkg for the result layout, phase and stop codes.
`timescale 1ns / 1ps

module record_log_scanner_checker #(
   parameter int unsigned REGION_BYTES = 16384
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // word[31:0]
   input  logic                           req_tuser,   // start_req
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // found, latest_offset, latest_length, next_seq, append_at, stop_reason, zero fill
   input  logic [rls_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             mismatches,
   output int                             pending
);
   import rls_pkg::*;

   localparam logic [31:0] REGION       = REGION_BYTES;
   localparam int          REPORT_LIMIT = 10;

   // scanner state, kept 32 bits wide and cut to 15 bits only on the result
   phase_type   phase;
   logic [31:0] scan_offset;
   logic [31:0] record_start;
   logic [31:0] record_length;
   logic [31:0] record_sequence;
   logic [31:0] record_check;
   logic [31:0] crc_state;
   logic [31:0] bytes_left;
   logic [31:0] best_offset;
   logic [31:0] best_length;
   logic [31:0] following_sequence;
   logic [31:0] append_offset;

   result_type  expected_summaries[$];

   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   task automatic restart_scan();
      phase              = PH_MAGIC;
      scan_offset        = '0;
      record_start       = '0;
      record_length      = '0;
      record_sequence    = '0;
      record_check       = '0;
      crc_state          = ALL_ONES;
      bytes_left         = '0;
      best_offset        = REGION;
      best_length        = '0;
      following_sequence = 32'd1;
      append_offset      = '0;
   endtask

   task automatic close_scan(input stop_type why);
      result_type r;
      r.found         = (best_offset < REGION);
      r.latest_offset = best_offset[FIELD_W-1:0];
      r.latest_length = best_length[FIELD_W-1:0];
      r.next_seq      = following_sequence;
      r.append_at     = append_offset[FIELD_W-1:0];
      r.stop_reason   = why;
      expected_summaries.push_back(r);
      phase = PH_STOPPED;
   endtask

   task automatic parse_word(input logic [31:0] w, input logic restart);
      logic [31:0] here;
      logic [31:0] padded;
      logic [31:0] take;
      if (restart) restart_scan();
      if (phase == PH_STOPPED) return;
      here        = scan_offset;
      scan_offset = here + 32'd4;
      case (phase)
         PH_MAGIC: begin
            if (w == ALL_ONES) close_scan(STOP_EMPTY);
            else if (w != LOG_MAGIC) close_scan(STOP_BAD_MAGIC);
            else begin
               record_start = here;
               phase        = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            if (w == 32'd0 || w > REGION) close_scan(STOP_BAD_LENGTH);
            else begin
               padded = (w + PAD_MASK) & ~PAD_MASK;
               if (record_start + HEADER_BYTES + padded > REGION) close_scan(STOP_OVERRUN);
               else begin
                  record_length = w;
                  phase         = PH_SEQ;
               end
            end
         end
         PH_SEQ: begin
            record_sequence = w;
            phase           = PH_CRC;
         end
         PH_CRC: begin
            record_check = w;
            crc_state    = ALL_ONES;
            bytes_left   = record_length;
            phase        = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            take = (bytes_left < 32'd4) ? bytes_left : 32'd4;
            for (int k = 0; k < 4; k++) begin
               if (k < take) crc_state = crc32_byte(crc_state, w[8*k +: 8]);
            end
            bytes_left = bytes_left - take;
            if (bytes_left == 32'd0) begin
               if (~crc_state != record_check) close_scan(STOP_CRC);
               else begin
                  best_offset        = record_start;
                  best_length        = record_length;
                  following_sequence = record_sequence + 32'd1;
                  append_offset      = record_start + HEADER_BYTES +
                                       ((record_length + PAD_MASK) & ~PAD_MASK);
                  scan_offset        = append_offset;
                  // fewer than a header's worth left: the region is exhausted
                  if (scan_offset + HEADER_BYTES > REGION) close_scan(STOP_REGION_END);
                  else phase = PH_MAGIC;
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      logic       bad;
      if (reset) begin
         restart_scan();
         expected_summaries.delete();
         mismatches = 0;
      end else begin
         if (req_tvalid && req_tready) parse_word(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[RESULT_W-1:0]);
            if (expected_summaries.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: scan result with none expected: found=%0b off=%0d len=%0d seq=%h app=%0d why=%0d",
                           $realtime, got.found, got.latest_offset, got.latest_length,
                           got.next_seq, got.append_at, got.stop_reason);
            end else begin
               want = expected_summaries.pop_front();
               bad  = (got.found !== want.found) ||
                      (got.latest_offset !== want.latest_offset) ||
                      (got.latest_length !== want.latest_length) ||
                      (got.next_seq !== want.next_seq) ||
                      (got.append_at !== want.append_at) ||
                      (got.stop_reason !== want.stop_reason);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: scan result mismatch", $realtime);
                     $display("   expected found=%0b off=%0d len=%0d seq=%h app=%0d why=%0d",
                              want.found, want.latest_offset, want.latest_length,
                              want.next_seq, want.append_at, want.stop_reason);
                     $display("   actual   found=%0b off=%0d len=%0d seq=%h app=%0d why=%0d",
                              got.found, got.latest_offset, got.latest_length,
                              got.next_seq, got.append_at, got.stop_reason);
                  end
               end
            end
         end
      end
      pending = expected_summaries.size();
   end

endmodule

@@ tb/record_log_scanner_core_tb.sv @@
// Testbench top for record_log_scanner_core: builds record logs word by word, drives them
// with random idling and back-pressure, and reports the verdict from the checker.
// Depends on rls_pkg, record_log_scanner_core and record_log_scanner_checker.
`timescale 1ns / 1ps

module record_log_scanner_core_tb;
   import rls_pkg::*;

   localparam int unsigned REGION_SIZE     = 16384;
   localparam int          RANDOM_WORDS    = 1900;
   localparam int          CALM_WORDS      = 300;
   localparam int          PRESSURE_WORDS  = 40;
   localparam int          HOLD_CYCLES     = 300;
   localparam int          DRAIN_CYCLES    = 12;
   localparam int          WATCHDOG_LIMIT  = 4000;

   typedef enum logic [2:0] {
      END_EMPTY, END_MAGIC, END_LENGTH, END_OVERRUN, END_CRC, END_CUT
   } ending_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int          mismatches;
   int          pending;
   bit          idle_on      = 1'b1;
   bit          hold_request = 1'b0;
   int          scan_items   = 0;
   logic [31:0] scan_words[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   record_log_scanner_core #(.REGION_BYTES(REGION_SIZE)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   record_log_scanner_checker #(.REGION_BYTES(REGION_SIZE)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function automatic int unsigned pick_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(65, 400) : $urandom_range(1, 24);
   endfunction

   function automatic logic [31:0] pick_sequence();
      return ($urandom_range(0, 7) == 0) ? ALL_ONES : $urandom;
   endfunction

   // one transaction on the request channel; entered and left at a falling edge
   task automatic send_word(input logic [31:0] w, input logic restart);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tuser  <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_scan(input logic first_start);
      for (int i = 0; i < scan_words.size(); i++) begin
         send_word(scan_words[i], (i == 0) ? first_start : 1'b0);
      end
      scan_items += scan_words.size();
      scan_words.delete();
   endtask

   // header plus padded payload; pad bytes are random and lie outside the CRC
   task automatic push_record(input int unsigned len, input logic [31:0] seq, input bit corrupt);
      logic [31:0] crc;
      logic [31:0] w;
      int unsigned words;
      int unsigned crc_at;
      crc   = ALL_ONES;
      words = (len + PAD_MASK) / 4;
      scan_words.push_back(LOG_MAGIC);
      scan_words.push_back(len);
      scan_words.push_back(seq);
      crc_at = scan_words.size();
      scan_words.push_back(32'h0);
      for (int i = 0; i < words; i++) begin
         w = $urandom;
         for (int k = 0; k < 4; k++) begin
            if (4 * i + k < len) crc = crc_next(crc, w[8*k +: 8]);
         end
         scan_words.push_back(w);
      end
      crc = ~crc;
      if (corrupt) crc = crc ^ (32'h1 << $urandom_range(0, 31));
      scan_words[crc_at] = crc;
   endtask

   task automatic push_ending(input ending_type kind);
      logic [31:0] w;
      int unsigned pos;
      int unsigned len;
      int unsigned drop;
      case (kind)
         END_EMPTY: scan_words.push_back(ALL_ONES);
         END_MAGIC: begin
            if ($urandom_range(0, 1)) w = LOG_MAGIC ^ (32'h1 << $urandom_range(0, 31));
            else begin
               w = $urandom;
               if (w == LOG_MAGIC || w == ALL_ONES) w = 32'h0;
            end
            scan_words.push_back(w);
         end
         END_LENGTH: begin
            case ($urandom_range(0, 3))
               0: w = 32'h0;
               1: w = REGION_SIZE + 1;
               2: w = ALL_ONES;
               default: w = $urandom_range(ALL_ONES, REGION_SIZE + 1);
            endcase
            scan_words.push_back(LOG_MAGIC);
            scan_words.push_back(w);
         end
         END_OVERRUN: begin
            pos = scan_words.size() * 4;
            scan_words.push_back(LOG_MAGIC);
            scan_words.push_back($urandom_range(REGION_SIZE - pos - HEADER_BYTES + 1, REGION_SIZE));
         end
         END_CRC: push_record(pick_length(), pick_sequence(), 1'b1);
         default: begin
            // record broken off part way; the next start request restarts the scan
            len = pick_length();
            push_record(len, pick_sequence(), 1'b0);
            drop = $urandom_range(1, 4 + (len + PAD_MASK) / 4);
            repeat (drop) void'(scan_words.pop_back());
         end
      endcase
   endtask

   task automatic random_scan();
      ending_type kind;
      repeat ($urandom_range(0, 4)) push_record(pick_length(), pick_sequence(), 1'b0);
      kind = ending_type'($urandom_range(0, 5));
      push_ending(kind);
      send_scan(1'b1);
      // words after a stop are ignored until the next start
      if (kind != END_CUT && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) send_word($urandom, 1'b0);
   endtask

   // result side: short random stalls, plus one long hold on request
   initial begin : receiver
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("** record_log_scanner_core: FAILED **");
      $finish;
   end

   initial begin : stimulus
      bit pressed;
      pressed = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no start after reset: first word is offset 0, then an ignored word
      send_word(ALL_ONES, 1'b0);
      send_word(LOG_MAGIC, 1'b0);
      send_word(32'h0, 1'b1);
      scan_words = '{LOG_MAGIC, 32'h0};
      send_scan(1'b1);
      scan_words = '{LOG_MAGIC, REGION_SIZE + 1};
      send_scan(1'b1);
      scan_words = '{LOG_MAGIC, ALL_ONES};
      send_scan(1'b1);
      scan_words = '{LOG_MAGIC, REGION_SIZE};
      send_scan(1'b1);
      // sequence wraps to zero, then a CRC failure after a good record
      push_record(5, ALL_ONES, 1'b0);
      push_record(1, 32'h0, 1'b1);
      send_scan(1'b1);

      scan_items = 0;
      while (scan_items < RANDOM_WORDS) begin
         if (!pressed && scan_items >= RANDOM_WORDS / 3) begin
            // every transaction here yields a result while the receiver holds off
            pressed      = 1'b1;
            hold_request = 1'b1;
            repeat (PRESSURE_WORDS) send_word($urandom_range(0, 1) ? ALL_ONES : $urandom, 1'b1);
            scan_items += PRESSURE_WORDS;
         end
         if (scan_items >= RANDOM_WORDS - CALM_WORDS) idle_on = 1'b0;
         random_scan();
      end

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && pending == 0)
         $display("** record_log_scanner_core: PASSED **");
      else
         $display("** record_log_scanner_core: FAILED **");
      $finish;
   end

endmodule
